### sv/shf_pkg.sv
// Shared types, constants and functions for the SHA-256 hash and fold core.
package shf_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hstate_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} msg_t;

	typedef struct packed {
		logic [40:0] fold_value;
		logic [63:0] digest_word0;
		logic [63:0] digest_word1;
		logic [63:0] digest_word2;
		logic [63:0] digest_word3;
	} digest_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_COMP,
		ST_CHAIN,
		ST_FOLD,
		ST_OUT
	} shf_state_t;

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS       = 6'd56;
	localparam logic [5:0] LAST_POS      = 6'd63;
	localparam logic [5:0] LAST_ROUND    = 6'd63;
	localparam logic [4:0] LAST_FOLD     = 5'd31;

	localparam hstate_t IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam word_t K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t bsig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t ssig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

### sv/shf_msg_if.sv
// Handshake channel carrying message byte items into the core.
interface shf_msg_if import shf_pkg::*; ();
	logic valid;
	logic ready;
	msg_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/shf_digest_if.sv
// Handshake channel carrying digest and fold result items out of the core.
interface shf_digest_if import shf_pkg::*; ();
	logic valid;
	logic ready;
	digest_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/shf_round.sv
// One SHA-256 round and one message schedule step, shared across all rounds.
module shf_round import shf_pkg::*; (
	input  hstate_t work,
	input  word_t   round_key,
	input  word_t   w0,
	input  word_t   w1,
	input  word_t   w9,
	input  word_t   w14,
	output hstate_t work_next,
	output word_t   sched_next
);
	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	always_comb begin
		ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
		maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
		t1  = work[7] + bsig1(work[4]) + ch + round_key + w0;
		t2  = bsig0(work[0]) + maj;
		work_next[7] = work[6];
		work_next[6] = work[5];
		work_next[5] = work[4];
		work_next[4] = work[3] + t1;
		work_next[3] = work[2];
		work_next[2] = work[1];
		work_next[1] = work[0];
		work_next[0] = t1 + t2;
		sched_next   = ssig1(w14) + w9 + ssig0(w1) + w0;
	end
endmodule

### sv/sha256_string_hash_fold_core.sv
// Top level of the streaming SHA-256 hash and digest fold core.
// Takes at most one message byte per item (has_byte) and gives one result item per message,
// after the item with last set: the SHA-256 digest as four big-endian 64-bit words and a
// 41-bit fold of its 32 bytes. An item that fills a 64-byte block loads the round registers,
// and no further item is taken until 64 rounds on the single shared round unit and one chain
// update are done. On last, padding bytes are shifted into the block buffer one per cycle
// outside compression (64 - bytes held, plus 64 when the length field does not fit), with a
// step that shifts nothing before the length field; each full block is compressed in turn,
// then the digest is folded one byte at a time before the result is shown; input stays
// blocked until the result item is taken.
module sha256_string_hash_fold_core import shf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	shf_msg_if.sink      msg,
	shf_digest_if.source digest
);
	shf_state_t state_q, state_d, ret_q, ret_d;

	hstate_t      chain_q;
	hstate_t      work_q;
	logic [511:0] blk_q;
	logic [63:0]  len_q;
	logic [5:0]   fill_q;
	logic [5:0]   round_q;
	logic [4:0]   fidx_q;
	logic [40:0]  fold_q;

	logic         accept;
	logic         shift_en;
	logic [7:0]   shift_byte;
	logic         blk_full;
	logic [63:0]  len_bits;
	logic [7:0]   len_byte;
	logic [7:0]   fold_byte;
	logic [39:0]  fold_sum;
	hstate_t      work_next;
	word_t        sched_next;

	shf_round u_round (
		.work       (work_q),
		.round_key  (K_TABLE[round_q]),
		.w0         (blk_q[511:480]),
		.w1         (blk_q[479:448]),
		.w9         (blk_q[223:192]),
		.w14        (blk_q[63:32]),
		.work_next  (work_next),
		.sched_next (sched_next)
	);

	assign accept    = msg.valid && msg.ready;
	assign len_bits  = {len_q[60:0], 3'b000};
	assign len_byte  = len_bits[{~fill_q[2:0], 3'b000} +: 8];
	assign fold_byte = chain_q[fidx_q[4:2]][{~fidx_q[1:0], 3'b000} +: 8];
	assign fold_sum  = fold_q[39:0] + {32'b0, fold_byte};
	assign blk_full  = shift_en && (fill_q == LAST_POS);

	always_comb begin
		msg.ready    = 1'b0;
		digest.valid = 1'b0;
		shift_en     = 1'b0;
		shift_byte   = 8'h00;
		case (state_q)
			ST_IDLE: begin
				msg.ready  = 1'b1;
				shift_en   = msg.valid && msg.payload.has_byte;
				shift_byte = msg.payload.data_byte;
			end
			ST_PAD_MARK: begin
				shift_en   = 1'b1;
				shift_byte = PAD_MARK_BYTE;
			end
			ST_PAD_ZERO: begin
				shift_en = (fill_q != LEN_POS);
			end
			ST_PAD_LEN: begin
				shift_en   = 1'b1;
				shift_byte = len_byte;
			end
			ST_OUT: begin
				digest.valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (blk_full) begin
						state_d = ST_COMP;
						ret_d   = msg.payload.last ? ST_PAD_MARK : ST_IDLE;
					end else if (msg.payload.last) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_PAD_MARK: begin
				if (blk_full) begin
					state_d = ST_COMP;
					ret_d   = ST_PAD_ZERO;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (fill_q == LEN_POS) begin
					state_d = ST_PAD_LEN;
				end else if (blk_full) begin
					state_d = ST_COMP;
					ret_d   = ST_PAD_ZERO;
				end
			end
			ST_PAD_LEN: begin
				if (blk_full) begin
					state_d = ST_COMP;
					ret_d   = ST_FOLD;
				end
			end
			ST_COMP: begin
				if (round_q == LAST_ROUND) begin
					state_d = ST_CHAIN;
				end
			end
			ST_CHAIN: begin
				state_d = ret_q;
			end
			ST_FOLD: begin
				if (fidx_q == LAST_FOLD) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (digest.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			chain_q <= IV;
			len_q   <= '0;
			fill_q  <= '0;
			round_q <= '0;
			fidx_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (accept && msg.payload.has_byte) begin
				len_q <= len_q + 64'd1;
			end
			if (blk_full) begin
				round_q <= '0;
			end else if (state_q == ST_COMP) begin
				round_q <= round_q + 6'd1;
			end
			if (state_q == ST_CHAIN) begin
				fidx_q <= '0;
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end else if (state_q == ST_FOLD) begin
				fidx_q <= fidx_q + 5'd1;
			end
			if (state_q == ST_OUT && digest.ready) begin
				chain_q <= IV;
				len_q   <= '0;
				fill_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= {blk_q[503:0], shift_byte};
		end else if (state_q == ST_COMP) begin
			blk_q <= {blk_q[479:0], sched_next};
		end
		if (blk_full) begin
			work_q <= chain_q;
		end else if (state_q == ST_COMP) begin
			work_q <= work_next;
		end
		if (state_q == ST_CHAIN) begin
			fold_q <= '0;
		end else if (state_q == ST_FOLD) begin
			fold_q <= {fold_sum, 1'b0};
		end
	end

	always_comb begin
		digest.payload.fold_value   = fold_q;
		digest.payload.digest_word0 = {chain_q[0], chain_q[1]};
		digest.payload.digest_word1 = {chain_q[2], chain_q[3]};
		digest.payload.digest_word2 = {chain_q[4], chain_q[5]};
		digest.payload.digest_word3 = {chain_q[6], chain_q[7]};
	end
endmodule

### sv/shf_checker.sv
// Port-level assertions for the hash and fold core, bound to its top level.
module shf_checker import shf_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    msg_valid,
	input logic    msg_ready,
	input logic    msg_last,
	input logic    dig_valid,
	input logic    dig_ready,
	input digest_t dig_payload
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && dig_valid))
		else $error("input taken while a result item is pending");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && msg_ready && msg_last) |=> !msg_ready)
		else $error("input not held off after the last item of a message");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && dig_ready) |=> (!dig_valid && msg_ready))
		else $error("result repeated or core not idle after result item");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && !dig_ready) |=> (dig_valid && $stable(dig_payload)))
		else $error("stalled result item changed");
endmodule

bind sha256_string_hash_fold_core shf_checker u_shf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.msg_valid   (msg.valid),
	.msg_ready   (msg.ready),
	.msg_last    (msg.payload.last),
	.dig_valid   (digest.valid),
	.dig_ready   (digest.ready),
	.dig_payload (digest.payload)
);
